// File: hw/rtl/wgm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types and constants for the wildcard glob matcher: transfer payloads,
// command codes, and the structs that pass between the cells.
// ----------------------------------------------------------------------------
package wgm_pkg;

    // pattern geometry
    localparam int PATTERN_MAX = 32;
    localparam int IDX_W       = 5;
    localparam int LEN_W       = 6;
    localparam int CNT_W       = 6;

    localparam logic [CNT_W-1:0] COUNT_MAX     = 6'd63;
    localparam logic [7:0]       STAR_BYTE     = 8'd42;
    localparam logic [7:0]       QUESTION_BYTE = 8'd63;
    localparam logic [7:0]       NUL_BYTE      = 8'd0;

    // command codes
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_TEXT   = 2'd1;
    localparam logic [1:0] CMD_END    = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // input transfer payload
    typedef struct packed {
        logic [1:0]       cmd;
        logic [IDX_W-1:0] position;
        logic [7:0]       byte_value;
    } t_in_item;

    // output transfer payload
    typedef struct packed {
        logic matched;
        logic glob_matched;
        logic prefix_matched;
    } t_out_item;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic             fresh;
        logic             text_en;
        logic             load_en;
        logic             clear;
        logic [IDX_W-1:0] position;
        logic [7:0]       byte_value;
        logic [LEN_W-1:0] plen;
        logic [CNT_W-1:0] count;
    } t_cell_ctl;

    // signals handed from one cell to the next
    typedef struct packed {
        logic carry;    // closed active bit carried over a star
        logic advance;  // active bit moved on by a matching byte
        logic alive;    // this position is inside the effective pattern
        logic star;     // this position holds a star
    } t_chain;

    // per-cell contributions to the verdict
    typedef struct packed {
        logic glob;
        logic prefix_end;
        logic mismatch;
    } t_cell_rpt;

endpackage

// File: hw/rtl/wgm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgm_cell
// One pattern position: holds the pattern byte and the active bit for that
// position, closes over stars and hands the next-position bits to its neighbour.
// ----------------------------------------------------------------------------
module wgm_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [wgm_pkg::IDX_W-1:0]       i_index,
    input  wgm_pkg::t_cell_ctl              i_ctl,
    input  wgm_pkg::t_chain                 i_chain,
    output wgm_pkg::t_chain                 o_chain,
    output wgm_pkg::t_cell_rpt              o_rpt
);

    logic [7:0] r_byte;
    logic       r_act;
    logic       n_act;

    logic w_v;
    logic w_vc;
    logic w_in_use;
    logic w_star;
    logic w_hit;
    logic w_end;
    logic [wgm_pkg::LEN_W-1:0] w_idx_ext;

    assign w_idx_ext = {1'b0, i_index};

    // active bit, with a fresh text seen as position zero only
    assign w_v  = i_ctl.fresh ? (i_index == '0) : r_act;
    assign w_vc = w_v | i_chain.carry;

    // position lies inside the effective pattern
    assign w_in_use = i_chain.alive & (w_idx_ext < i_ctl.plen)
                    & (r_byte != wgm_pkg::NUL_BYTE);
    assign w_star   = (r_byte == wgm_pkg::STAR_BYTE);
    assign w_hit    = (r_byte == wgm_pkg::QUESTION_BYTE) | (r_byte == i_ctl.byte_value);
    assign w_end    = i_chain.alive & ~w_in_use;

    // hand-over to the next position
    assign o_chain.carry   = w_vc & w_in_use & w_star;
    assign o_chain.advance = w_vc & w_in_use & ~w_star & w_hit;
    assign o_chain.alive   = w_in_use;
    assign o_chain.star    = w_star;

    // verdict contributions: glob and prefix end where the pattern ends at this position, mismatch at the text count
    assign o_rpt.glob       = w_vc & w_end;
    assign o_rpt.prefix_end = w_end & ~i_chain.star & (i_ctl.count >= w_idx_ext);
    assign o_rpt.mismatch   = w_in_use & (i_ctl.count == w_idx_ext)
                            & (r_byte != i_ctl.byte_value);

    // next active bit
    always_comb begin
        n_act = r_act;
        if (i_ctl.clear) begin
            n_act = 1'b0;
        end else if (i_ctl.text_en) begin
            n_act = o_chain.carry | i_chain.advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else begin
            r_act <= n_act;
        end
    end

    // pattern byte store
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_en && (i_ctl.position == i_index)) begin
            r_byte <= i_ctl.byte_value;
        end
    end

endmodule

// File: hw/rtl/wildcard_glob_matcher_top.sv
`timescale 1ns / 1ps
// Result: an end-of-text item gives its result in the output register in the cycle
//   after the transfer; load and text items give no result.
// Throughput: one item per cycle while the output slot can move, set by the single pass through the cell row.
// Reset (synchronous, active low) clears the active bits, text count, length
//   register and output valid; pattern bytes keep their contents.
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_top
// Streams text bytes through a row of pattern cells and reports whether the
// text matches the stored wildcard pattern or starts with it literally.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  wgm_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output wgm_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_we,
    input  logic [wgm_pkg::LEN_W-1:0]     i_cfg_data
);

    localparam int N = wgm_pkg::PATTERN_MAX;

    logic [wgm_pkg::LEN_W-1:0] r_plen;
    logic [wgm_pkg::CNT_W-1:0] r_count;
    logic [wgm_pkg::CNT_W-1:0] n_count;
    logic                      r_prefix_eq;
    logic                      n_prefix_eq;
    logic                      r_act_end;
    logic                      n_act_end;
    logic                      r_out_valid;
    logic                      n_out_valid;
    wgm_pkg::t_out_item        r_out_item;
    wgm_pkg::t_out_item        n_out_item;

    logic                      w_in_acc;
    logic                      w_is_load;
    logic                      w_is_text;
    logic                      w_is_end;
    wgm_pkg::t_cell_ctl        w_ctl;
    wgm_pkg::t_chain           w_chain [0:N];
    logic [N:0]                w_glob;
    logic [N:0]                w_prefix_end;
    logic [N-1:0]              w_mismatch;
    logic                      w_vc_end;
    logic                      w_glob_hit;
    logic                      w_prefix_hit;

    // handshake: a new item is taken whenever the output slot can move
    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign w_in_acc   = i_in_valid & o_in_ready;

    // command decode
    always_comb begin
        w_is_load = 1'b0;
        w_is_text = 1'b0;
        w_is_end  = 1'b0;
        unique case (i_in_item.cmd)
            wgm_pkg::CMD_LOAD: w_is_load = w_in_acc;
            wgm_pkg::CMD_TEXT: w_is_text = w_in_acc;
            wgm_pkg::CMD_END:  w_is_end  = w_in_acc;
            default:           ;
        endcase
    end

    // broadcast control
    assign w_ctl.fresh      = (r_count == '0);
    assign w_ctl.text_en    = w_is_text;
    assign w_ctl.load_en    = w_is_load;
    assign w_ctl.clear      = w_is_end;
    assign w_ctl.position   = i_in_item.position;
    assign w_ctl.byte_value = i_in_item.byte_value;
    assign w_ctl.plen       = r_plen;
    assign w_ctl.count      = r_count;

    // head of the chain
    assign w_chain[0].carry   = 1'b0;
    assign w_chain[0].advance = 1'b0;
    assign w_chain[0].alive   = 1'b1;
    assign w_chain[0].star    = 1'b0;

    // row of pattern cells
    for (genvar g = 0; g < N; g++) begin : g_cell
        wgm_pkg::t_cell_rpt w_rpt;

        wgm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (wgm_pkg::IDX_W'(g)),
            .i_ctl   (w_ctl),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1]),
            .o_rpt   (w_rpt)
        );

        assign w_glob[g]       = w_rpt.glob;
        assign w_prefix_end[g] = w_rpt.prefix_end;
        assign w_mismatch[g]   = w_rpt.mismatch;
    end

    // position past the last cell
    assign w_vc_end        = (~w_ctl.fresh & r_act_end) | w_chain[N].carry;
    assign w_glob[N]       = w_vc_end & w_chain[N].alive;
    assign w_prefix_end[N] = w_chain[N].alive & ~w_chain[N].star
                           & (r_count >= wgm_pkg::CNT_W'(N));

    // verdict
    assign w_glob_hit   = |w_glob;
    assign w_prefix_hit = w_chain[1].alive & r_prefix_eq & (|w_prefix_end);

    // next state of text tracking and output slot
    always_comb begin
        n_count     = r_count;
        n_prefix_eq = r_prefix_eq;
        n_act_end   = r_act_end;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_out_item  = r_out_item;
        if (w_is_text) begin
            if (r_count != wgm_pkg::COUNT_MAX) begin
                n_count = r_count + wgm_pkg::CNT_W'(1);
            end
            if (|w_mismatch) begin
                n_prefix_eq = 1'b0;
            end
            n_act_end = w_chain[N].advance;
        end else if (w_is_end) begin
            n_count                   = '0;
            n_prefix_eq               = 1'b1;
            n_act_end                 = 1'b0;
            n_out_valid               = 1'b1;
            n_out_item.matched        = w_glob_hit | w_prefix_hit;
            n_out_item.glob_matched   = w_glob_hit;
            n_out_item.prefix_matched = w_prefix_hit;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen      <= '0;
            r_count     <= '0;
            r_prefix_eq <= 1'b1;
            r_act_end   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_plen <= i_cfg_data;
            end
            r_count     <= n_count;
            r_prefix_eq <= n_prefix_eq;
            r_act_end   <= n_act_end;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // end of text restarts the text tracking
    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_is_end |=> (r_count == '0) && r_prefix_eq && !r_act_end)
        else $error("text state not restarted after end transfer");

    // a result appears only after an end transfer
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_is_end))
        else $error("result without end transfer");

    // text transfers advance the count until saturation
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_is_text && (r_count != wgm_pkg::COUNT_MAX))
            |=> (r_count == $past(r_count) + wgm_pkg::CNT_W'(1)))
        else $error("text count did not advance");

    // combined verdict agrees with its parts
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.matched ==
                         (o_out_item.glob_matched | o_out_item.prefix_matched)))
        else $error("matched disagrees with glob and prefix verdicts");

endmodule
